[rtl/wfa_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Worst-fit allocator package
// Shared constants, codes and types for the worst-fit block allocator.
// ----------------------------------------------------------------------------
package wfa_pkg;

  localparam int unsigned MaxBlocksDefault   = 64;
  localparam int unsigned HeaderBytesDefault = 8;
  localparam int unsigned OffW   = 24;
  localparam int unsigned LenW   = 25;
  localparam logic [LenW-1:0] RegionCap = 25'h100_0000;

  typedef enum logic [1:0] {
    REQ_ALLOC = 2'd0,
    REQ_FREE  = 2'd1,
    REQ_QUERY = 2'd2,
    REQ_BAD   = 2'd3
  } req_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_INVALID  = 2'd1,
    ST_NO_MEM   = 2'd2,
    ST_NOTFOUND = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_DECIDE,
    S_SHIFT,
    S_OUT
  } fsm_e;

  // One table entry as it moves along the chain.
  typedef struct packed {
    logic            used;
    logic [OffW-1:0] start;
    logic [LenW-1:0] len;
  } entry_t;

  // Per-cycle command broadcast from the controller to every cell.
  typedef struct packed {
    logic            rot;     // rotate entries one cell toward the head
    logic            ins;     // tail cell takes new_ent instead of the wrap
    entry_t          new_ent;
  } cell_cmd_t;

endpackage

[rtl/wfa_cell.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Worst-fit allocator table cell
// Holds one table entry and passes it to its neighbor when the ring rotates.
// ----------------------------------------------------------------------------
module wfa_cell (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  wfa_pkg::cell_cmd_t   cmd_i,
  input  logic                 is_tail_i,
  input  wfa_pkg::entry_t      from_next_i,
  output wfa_pkg::entry_t      ent_o
);

  logic                     used_q;
  logic [wfa_pkg::OffW-1:0] start_q;
  logic [wfa_pkg::LenW-1:0] len_q;
  wfa_pkg::entry_t          ent_d;

  // Shift in from the neighbor; the tail cell may take the broadcast entry.
  always_comb begin
    ent_d = ent_o;
    if (cmd_i.rot) begin
      ent_d = from_next_i;
      if (is_tail_i && cmd_i.ins) begin
        ent_d = cmd_i.new_ent;
      end
    end
  end

  // Only the used flag needs reset; start and length are don't-care until written.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_q <= 1'b0;
    end else begin
      used_q <= ent_d.used;
    end
  end

  always_ff @(posedge clk_i) begin
    start_q <= ent_d.start;
    len_q   <= ent_d.len;
  end

  assign ent_o = {used_q, start_q, len_q};

endmodule

[rtl/worst_fit_block_allocator.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Worst-fit block allocator
// Address-ordered table of allocated blocks kept in a ring of cells.
// ----------------------------------------------------------------------------
// The block table lives in a ring of MAX_BLOCKS cells whose head cell holds
// the lowest-addressed block. Every request that passes the early checks
// rotates the ring once around, looking at one entry per cycle at the head.
// Allocate needs two laps (one to find the largest hole, one to insert the
// new entry at its place); free, query and an allocate that finds no room
// take one lap. Requests that fail argument checks, allocates with a full
// table or no region set, and null frees skip the laps. One request is in
// flight at a time; its result waits in an output register until taken.
module worst_fit_block_allocator #(
  parameter int unsigned MAX_BLOCKS   = wfa_pkg::MaxBlocksDefault,
  parameter int unsigned HEADER_BYTES = wfa_pkg::HeaderBytesDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [24:0] cfg_wdata_i,   // region_bytes
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [1:0] req_type, [26:2] request_size, [50:27] payload_offset
  input  logic [55:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [1:0] status, [25:2] granted_offset, [50:26] block_length, [51] is_valid
  output logic [55:0] m_axis_tdata
);

  localparam int unsigned IdxW = $clog2(MAX_BLOCKS);
  localparam int unsigned CntW = $clog2(MAX_BLOCKS + 1);
  localparam int unsigned OffW = wfa_pkg::OffW;
  localparam int unsigned LenW = wfa_pkg::LenW;
  localparam int unsigned SumW = 27;
  localparam logic [SumW-1:0] Hdr = SumW'(HEADER_BYTES);
  localparam logic [IdxW-1:0] LastIdx = IdxW'(MAX_BLOCKS - 1);
  localparam logic [CntW-1:0] MaxCnt = CntW'(MAX_BLOCKS);

  // Configuration register, clamped at the region cap.
  logic [LenW-1:0] region_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      region_q <= '0;
    end else if (cfg_we_i) begin
      region_q <= (cfg_wdata_i > wfa_pkg::RegionCap) ? wfa_pkg::RegionCap : cfg_wdata_i;
    end
  end

  // Cell ring.
  wfa_pkg::cell_cmd_t cmd;
  wfa_pkg::entry_t    ents [MAX_BLOCKS];

  for (genvar g = 0; g < MAX_BLOCKS; g++) begin : g_cell
    wfa_cell u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .cmd_i       (cmd),
      .is_tail_i   (g == MAX_BLOCKS - 1),
      .from_next_i (ents[(g + 1) % MAX_BLOCKS]),
      .ent_o       (ents[g])
    );
  end

  wfa_pkg::entry_t head;
  assign head = ents[0];

  // Request registers.
  wfa_pkg::fsm_e    state_q, state_d;
  logic [1:0]       req_q;
  logic [LenW-1:0]  size_q;
  logic [OffW-1:0]  off_q;
  logic [IdxW-1:0]  step_q, step_d;
  logic [CntW-1:0]  count_q, count_d;
  logic [SumW-1:0]  prev_end_q, prev_end_d;
  logic [SumW-1:0]  best_q, best_d;
  logic [OffW-1:0]  best_at_q, best_at_d;
  logic [CntW-1:0]  pos_q, pos_d;
  logic             found_q, found_d;
  logic [LenW-1:0]  flen_q, flen_d;
  logic [1:0]       st_q, st_d;
  logic [OffW-1:0]  gofs_q, gofs_d;
  logic [LenW-1:0]  olen_q, olen_d;
  logic             oval_q, oval_d;
  wfa_pkg::entry_t  hold_q, hold_d;

  // Datapath terms on the head entry.
  logic [SumW-1:0] head_end, head_pay, lim, hole;
  logic            hit;
  always_comb begin
    head_pay = SumW'(head.start) + Hdr;
    head_end = head_pay + SumW'(head.len);
    lim      = head.used ? SumW'(head.start) : SumW'(region_q);
    hole     = (lim > prev_end_q) ? lim - prev_end_q : '0;
    hit      = head.used && (off_q != '0) && (SumW'(off_q) >= head_pay)
               && (SumW'(off_q) < head_end);
  end

  logic in_acc, out_acc;
  assign in_acc  = s_axis_tvalid && s_axis_tready;
  assign out_acc = m_axis_tvalid && m_axis_tready;
  assign s_axis_tready = (state_q == wfa_pkg::S_IDLE);
  assign m_axis_tvalid = (state_q == wfa_pkg::S_OUT);
  assign m_axis_tdata  = {4'b0, oval_q, olen_q, gofs_q, st_q};

  // Control: next state, ring commands and result.
  always_comb begin
    state_d    = state_q;
    step_d     = step_q;
    count_d    = count_q;
    prev_end_d = prev_end_q;
    best_d     = best_q;
    best_at_d  = best_at_q;
    pos_d      = pos_q;
    found_d    = found_q;
    flen_d     = flen_q;
    st_d       = st_q;
    gofs_d     = gofs_q;
    olen_d     = olen_q;
    oval_d     = oval_q;
    hold_d     = hold_q;
    cmd        = '0;
    case (state_q)
      wfa_pkg::S_IDLE: begin
        step_d = '0; prev_end_d = '0; best_d = '0;
        best_at_d = '0; pos_d = '0; found_d = 1'b0; flen_d = '0;
        st_d = wfa_pkg::ST_OK; gofs_d = '0; olen_d = '0; oval_d = 1'b0;
        if (in_acc) begin
          state_d = wfa_pkg::S_SCAN;
          case (wfa_pkg::req_e'(s_axis_tdata[1:0]))
            wfa_pkg::REQ_ALLOC: begin
              if (s_axis_tdata[26:2] == '0) begin
                st_d = wfa_pkg::ST_INVALID; state_d = wfa_pkg::S_OUT;
              end else if (region_q == '0 || count_q >= MaxCnt) begin
                st_d = wfa_pkg::ST_NO_MEM; state_d = wfa_pkg::S_OUT;
              end
            end
            wfa_pkg::REQ_FREE: begin
              if (s_axis_tdata[50:27] == '0) state_d = wfa_pkg::S_OUT;
            end
            wfa_pkg::REQ_QUERY: ;
            default: begin
              st_d = wfa_pkg::ST_INVALID; state_d = wfa_pkg::S_OUT;
            end
          endcase
        end
      end
      wfa_pkg::S_SCAN: begin
        cmd.rot = 1'b1;
        if (req_q == wfa_pkg::REQ_ALLOC) begin
          // Holes before each used entry and the tail hole once.
          if (CntW'(step_q) <= count_q && (head.used || CntW'(step_q) == count_q)) begin
            if (hole > best_q) begin
              best_d = hole; best_at_d = prev_end_q[OffW-1:0]; pos_d = CntW'(step_q);
            end
            if (head.used) prev_end_d = head_end;
          end
        end else begin
          if (hit && !found_q) begin
            found_d = 1'b1; flen_d = head.len;
          end
          // Free: from the hit on, the tail takes the entry behind the head,
          // which closes the gap; the last step brings in an empty entry.
          if (req_q == wfa_pkg::REQ_FREE && (found_q || hit)) begin
            cmd.ins = 1'b1;
            if (step_q == LastIdx) begin
              cmd.new_ent = '0;
            end else begin
              cmd.new_ent = ents[1];
            end
          end
        end
        step_d = step_q + 1'b1;
        if (step_q == LastIdx) begin
          step_d = '0;
          state_d = wfa_pkg::S_DECIDE;
        end
      end
      wfa_pkg::S_DECIDE: begin
        // Allocate goes on to the insert lap if the size fits; free has already compacted.
        state_d = wfa_pkg::S_OUT;
        case (wfa_pkg::req_e'(req_q))
          wfa_pkg::REQ_ALLOC: begin
            if ((SumW'(size_q) + Hdr) > best_q) begin
              st_d = wfa_pkg::ST_NO_MEM;
            end else begin
              state_d = wfa_pkg::S_SHIFT;
            end
          end
          wfa_pkg::REQ_FREE: begin
            if (found_q) begin
              count_d = count_q - 1'b1;
            end else st_d = wfa_pkg::ST_NOTFOUND;
          end
          wfa_pkg::REQ_QUERY: begin
            if (found_q) begin
              olen_d = flen_q; oval_d = 1'b1;
            end else st_d = wfa_pkg::ST_NOTFOUND;
          end
          default: st_d = wfa_pkg::ST_INVALID;
        endcase
      end
      wfa_pkg::S_SHIFT: begin
        // Insert lap: at pos the tail takes the new entry, and from then on
        // each head entry is held back one step, so the rest move up by one.
        // The last entry, always empty, stays in the hold register.
        cmd.rot = 1'b1;
        if (CntW'(step_q) == pos_q) begin
          cmd.ins = 1'b1;
          cmd.new_ent.used  = 1'b1;
          cmd.new_ent.start = best_at_q;
          cmd.new_ent.len   = size_q;
          hold_d = head;
        end else if (CntW'(step_q) > pos_q) begin
          cmd.ins = 1'b1;
          cmd.new_ent = hold_q;
          hold_d = head;
        end
        step_d = step_q + 1'b1;
        if (step_q == LastIdx) begin
          step_d  = '0;
          state_d = wfa_pkg::S_OUT;
          count_d = count_q + 1'b1;
          gofs_d  = best_at_q + OffW'(HEADER_BYTES);
        end
      end
      wfa_pkg::S_OUT: begin
        if (out_acc) state_d = wfa_pkg::S_IDLE;
      end
      default: state_d = wfa_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= wfa_pkg::S_IDLE;
      count_q <= '0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      req_q  <= s_axis_tdata[1:0];
      size_q <= s_axis_tdata[26:2];
      off_q  <= s_axis_tdata[50:27];
    end
    step_q <= step_d; prev_end_q <= prev_end_d;
    best_q <= best_d; best_at_q <= best_at_d; pos_q <= pos_d;
    found_q <= found_d; flen_q <= flen_d; st_q <= st_d;
    gofs_q <= gofs_d; olen_q <= olen_d; oval_q <= oval_d;
    hold_q <= hold_d;
  end

  // Checks on the control logic.
  a_cnt_max: assert property (@(posedge clk_i) disable iff (!rst_ni) count_q <= MaxCnt)
    else $error("block count above table size");
  a_one_side: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(s_axis_tready && m_axis_tvalid)) else $error("accepting while result pending");
  a_ins_rot: assert property (@(posedge clk_i) disable iff (!rst_ni) cmd.ins |-> cmd.rot)
    else $error("tail load without rotation");

endmodule
